[sv/iuart_pkg.sv]
`timescale 1ns / 1ps

package iuart_pkg;

  localparam int unsigned DATA_BITS_DEF = 8;
  localparam int unsigned PH_W = 4;
  localparam int unsigned BT_W = 16;
  localparam int unsigned WAIT_MS_W = 10;
  localparam int unsigned WAIT_W = WAIT_MS_W + BT_W;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [BT_W-1:0] BIT_TICKS_RST = 16'd417;
  localparam logic [BT_W-1:0] TICKS_PER_MS_RST = 16'd1000;
  localparam logic [BT_W-1:0] BIT_TICKS_MIN = 16'd2;

  localparam logic [PH_W-1:0] PH_IDLE = 4'd0;
  localparam logic [PH_W-1:0] PH_START = 4'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIT_TICKS    = 2'd0,
    CFG_TICKS_PER_MS = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    RX_ST_OK          = 2'd0,
    RX_ST_TIMEOUT     = 2'd1,
    RX_ST_FALSE_START = 2'd2
  } rx_status_e;

  typedef struct packed {
    logic                 rx_line;
    logic                 tx_start;
    logic [7:0]           tx_byte;
    logic                 rx_arm;
    logic [WAIT_MS_W-1:0] rx_wait_ms;
  } iuart_in_t;

  typedef struct packed {
    logic       tx_line;
    logic       tx_ready;
    logic       rx_busy;
    logic       rx_done;
    logic [1:0] rx_status;
    logic [7:0] rx_byte;
  } iuart_out_t;

  typedef struct packed {
    logic line;
    logic ready;
  } tx_res_t;

  typedef struct packed {
    logic       busy;
    logic       done;
    rx_status_e status;
    logic [7:0] data;
  } rx_res_t;

endpackage

[sv/iuart_tx.sv]
`timescale 1ns / 1ps

module iuart_tx import iuart_pkg::*; #(
  parameter int unsigned DATA_BITS = DATA_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic [BT_W-1:0] bit_ticks_i,
  input  logic            start_i,
  input  logic [7:0]      byte_i,
  output tx_res_t         res_o
);

  localparam logic [PH_W-1:0] TX_DATA0 = PH_W'(2);
  localparam logic [PH_W-1:0] TX_PAR = PH_W'(2 + DATA_BITS);
  localparam logic [PH_W-1:0] TX_STOP_LAST = PH_W'(4 + DATA_BITS);
  localparam logic [7:0] PAR_MASK = (DATA_BITS >= 8) ? 8'hFF : 8'((1 << DATA_BITS) - 1);

  logic [PH_W-1:0] phase_q, phase_d;
  logic [BT_W-1:0] cnt_q, cnt_d;
  logic [7:0]      shift_q, shift_d;
  logic            parity_q, parity_d;
  logic [BT_W:0]   cnt_inc;
  logic            in_data_q;
  logic            in_data_d;

  assign cnt_inc   = {1'b0, cnt_q} + {{BT_W{1'b0}}, 1'b1};
  assign in_data_q = (phase_q >= TX_DATA0) && (phase_q < TX_PAR);
  assign in_data_d = (phase_d >= TX_DATA0) && (phase_d < TX_PAR);

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    shift_d  = shift_q;
    parity_d = parity_q;
    if (en_i) begin
      if (phase_q == PH_IDLE) begin
        if (start_i) begin
          shift_d  = byte_i;
          parity_d = ^(byte_i & PAR_MASK);
          phase_d  = PH_START;
          cnt_d    = '0;
        end
      end else if (cnt_inc >= {1'b0, bit_ticks_i}) begin
        cnt_d = '0;
        if (in_data_q) begin
          shift_d = shift_q >> 1;
        end
        if (phase_q >= TX_STOP_LAST) begin
          phase_d = PH_IDLE;
        end else begin
          phase_d = phase_q + PH_W'(1);
        end
      end else begin
        cnt_d = cnt_inc[BT_W-1:0];
      end
    end
  end

  always_comb begin
    res_o.ready = (phase_d == PH_IDLE);
    if (phase_d == PH_START) begin
      res_o.line = 1'b1;
    end else if (in_data_d) begin
      res_o.line = ~shift_d[0];
    end else if (phase_d == TX_PAR) begin
      res_o.line = ~parity_d;
    end else begin
      res_o.line = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      cnt_q    <= '0;
      shift_q  <= '0;
      parity_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      shift_q  <= shift_d;
      parity_q <= parity_d;
    end
  end

endmodule

[sv/iuart_rx.sv]
`timescale 1ns / 1ps

module iuart_rx import iuart_pkg::*; #(
  parameter int unsigned DATA_BITS = DATA_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic [BT_W-1:0]      bit_ticks_i,
  input  logic [BT_W-1:0]      ticks_per_ms_i,
  input  logic                 line_i,
  input  logic                 arm_i,
  input  logic [WAIT_MS_W-1:0] wait_ms_i,
  output rx_res_t              res_o
);

  localparam logic [PH_W-1:0] RX_WAIT = PH_W'(1);
  localparam logic [PH_W-1:0] RX_HALF = PH_W'(2);
  localparam logic [PH_W-1:0] RX_DATA0 = PH_W'(3);
  localparam logic [PH_W-1:0] RX_TAIL0 = PH_W'(3 + DATA_BITS);
  localparam logic [PH_W-1:0] RX_TAIL_LAST = PH_W'(5 + DATA_BITS);

  logic [PH_W-1:0]   phase_q, phase_d;
  logic [BT_W-1:0]   cnt_q, cnt_d;
  logic [WAIT_W-1:0] wait_q, wait_d;
  logic [7:0]        shift_q, shift_d;
  logic [BT_W:0]     cnt_inc;
  logic [WAIT_W-1:0] wait_limit;
  logic [PH_W-1:0]   idx;
  logic              done;
  rx_status_e        status;

  assign cnt_inc    = {1'b0, cnt_q} + {{BT_W{1'b0}}, 1'b1};
  assign wait_limit = WAIT_W'(wait_ms_i) * WAIT_W'(ticks_per_ms_i);
  assign idx        = phase_q - RX_DATA0;

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    wait_d  = wait_q;
    shift_d = shift_q;
    done    = 1'b0;
    status  = RX_ST_OK;
    if (en_i) begin
      if (phase_q == PH_IDLE) begin
        if (arm_i) begin
          phase_d = RX_WAIT;
          cnt_d   = '0;
          shift_d = '0;
          wait_d  = wait_limit;
        end
      end else if (phase_q == RX_WAIT) begin
        if (line_i) begin
          phase_d = RX_HALF;
          cnt_d   = '0;
        end else if (wait_q == '0) begin
          phase_d = PH_IDLE;
          done    = 1'b1;
          status  = RX_ST_TIMEOUT;
        end else begin
          wait_d = wait_q - WAIT_W'(1);
        end
      end else if (phase_q == RX_HALF) begin
        if (cnt_inc >= {2'b00, bit_ticks_i[BT_W-1:1]}) begin
          cnt_d = '0;
          if (!line_i) begin
            phase_d = PH_IDLE;
            done    = 1'b1;
            status  = RX_ST_FALSE_START;
          end else begin
            phase_d = RX_DATA0;
          end
        end else begin
          cnt_d = cnt_inc[BT_W-1:0];
        end
      end else if (cnt_inc < {1'b0, bit_ticks_i}) begin
        cnt_d = cnt_inc[BT_W-1:0];
      end else begin
        cnt_d = '0;
        if (phase_q < RX_TAIL0) begin
          if (!line_i && (idx < PH_W'(8))) begin
            shift_d[idx[2:0]] = 1'b1;
          end
          phase_d = phase_q + PH_W'(1);
        end else if (phase_q >= RX_TAIL_LAST) begin
          phase_d = PH_IDLE;
          done    = 1'b1;
          status  = RX_ST_OK;
        end else begin
          phase_d = phase_q + PH_W'(1);
        end
      end
    end
  end

  always_comb begin
    res_o.busy   = (phase_d != PH_IDLE);
    res_o.done   = done;
    res_o.status = status;
    res_o.data   = (done && status == RX_ST_OK) ? shift_d : 8'h00;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      wait_q  <= '0;
      shift_q <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      wait_q  <= wait_d;
      shift_q <= shift_d;
    end
  end

endmodule

[sv/inverted_uart_even_parity.sv]
// channel  direction  handshake               payload
// in       input      in_valid_i / in_stall_o   in_data_i   (iuart_in_t, one tick per beat)
// out      output     out_valid_o / out_stall_i out_data_o  (iuart_out_t, one per in beat)
// cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// one beat per cycle unless out stalls; beats go via input and result regs to out_data_o
// the tick update of both bit engines sits between the input and result registers
// reset returns both engines to idle and the registers to 417 and 1000 ticks
// a stall on out holds the result register and backs up through the input register
`timescale 1ns / 1ps

module inverted_uart_even_parity import iuart_pkg::*; #(
  parameter int unsigned DATA_BITS = DATA_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  iuart_in_t            in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output iuart_out_t           out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [BT_W-1:0]      cfg_data_i
);

  logic [BT_W-1:0] bit_ticks_q;
  logic [BT_W-1:0] ticks_per_ms_q;
  logic [BT_W-1:0] bit_eff;
  iuart_in_t       in_q;
  logic            in_valid_q;
  iuart_out_t      out_q;
  logic            out_valid_q;
  logic            adv;
  tx_res_t         tx_res;
  rx_res_t         rx_res;

  assign cfg_ready_o = 1'b1;
  assign bit_eff     = (bit_ticks_q < BIT_TICKS_MIN) ? BIT_TICKS_MIN : bit_ticks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_ticks_q    <= BIT_TICKS_RST;
      ticks_per_ms_q <= TICKS_PER_MS_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_BIT_TICKS:    bit_ticks_q    <= cfg_data_i;
        CFG_TICKS_PER_MS: ticks_per_ms_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign adv        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && out_valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  iuart_tx #(
    .DATA_BITS(DATA_BITS)
  ) u_tx (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .bit_ticks_i(bit_eff),
    .start_i    (in_q.tx_start),
    .byte_i     (in_q.tx_byte),
    .res_o      (tx_res)
  );

  iuart_rx #(
    .DATA_BITS(DATA_BITS)
  ) u_rx (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (adv),
    .bit_ticks_i   (bit_eff),
    .ticks_per_ms_i(ticks_per_ms_q),
    .line_i        (in_q.rx_line),
    .arm_i         (in_q.rx_arm),
    .wait_ms_i     (in_q.rx_wait_ms),
    .res_o         (rx_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.tx_line   <= tx_res.line;
      out_q.tx_ready  <= tx_res.ready;
      out_q.rx_busy   <= rx_res.busy;
      out_q.rx_done   <= rx_res.done;
      out_q.rx_status <= rx_res.status;
      out_q.rx_byte   <= rx_res.data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.rx_done |-> !out_data_o.rx_busy)
    else $error("receive reported done while still busy");

  a_byte_only_on_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.rx_byte != 8'h00) |->
      out_data_o.rx_done && (out_data_o.rx_status == RX_ST_OK))
    else $error("received byte shown outside a good receive");

  a_idle_line_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.tx_ready |-> !out_data_o.tx_line)
    else $error("transmit line high while transmitter idle");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q && !adv)
    else $error("input stalled without a held result");

endmodule
